// File: rtl/ps2s1_pkg.sv
// Package with the scancode constants, key kinds and UK layout tables for the decoder.
`timescale 1ns / 1ps

package ps2s1_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_UP   = 2'd1,
    KIND_DOWN = 2'd2
  } kind_e;

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_BREAK_BIT  = 8'h80;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_ARROW_UP   = 8'h48;
  localparam logic [7:0] SC_ARROW_DOWN = 8'h50;
  localparam logic [6:0] CASE_BIT      = 7'h20;

  // Entries past the last key code are zero, so any make code below 64 may index.
  localparam logic [6:0] PLAIN_TAB [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h23, 7'h00, 7'h23, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_TAB [64] = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h00, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h40, 7'h7E, 7'h00, 7'h7E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

// File: rtl/ps2_set1_scancode_to_ascii_top.sv
// Top level of the scancode set 1 to ASCII decoder.
`timescale 1ns / 1ps

// Takes one scancode set 1 byte per request and tracks shift, caps lock and the
// extended prefix. A make code of a printable key gives a character from the UK
// layout, and an extended up or down arrow gives an arrow request; all other bytes
// only update the flags or are dropped. One byte can be accepted every cycle while
// the output is not stalled; a byte passes through an input register and then a
// result register before its result appears.
module ps2_set1_scancode_to_ascii_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         scan_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ps2s1_pkg::kind_e   key_kind_o,
  output logic [6:0]         char_code_o
);
  import ps2s1_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic       prefix_q, prefix_d;
  logic       out_valid_q;
  kind_e      kind_q, kind_d;
  logic [6:0] char_q, char_d;
  logic       has_res;
  logic       out_free;
  logic       advance;
  logic [6:0] tab_ch;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!has_res || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    has_res  = 1'b0;
    kind_d   = KIND_CHAR;
    char_d   = 7'd0;
    tab_ch   = shift_q ? SHIFT_TAB[byte_q[5:0]] : PLAIN_TAB[byte_q[5:0]];
    if (byte_q == SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (byte_q == SC_LSHIFT || byte_q == SC_RSHIFT) begin
      shift_d = 1'b1;
    end else if (byte_q == (SC_LSHIFT | SC_BREAK_BIT) ||
                 byte_q == (SC_RSHIFT | SC_BREAK_BIT)) begin
      shift_d = 1'b0;
    end else if (byte_q == SC_CAPS) begin
      caps_d = !caps_q;
    end else if ((byte_q & SC_BREAK_BIT) != 8'd0) begin
      prefix_d = 1'b0;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (byte_q == SC_ARROW_UP) begin
        has_res = 1'b1;
        kind_d  = KIND_UP;
      end else if (byte_q == SC_ARROW_DOWN) begin
        has_res = 1'b1;
        kind_d  = KIND_DOWN;
      end
    end else if (!byte_q[6] && tab_ch != 7'd0) begin
      has_res = 1'b1;
      char_d  = tab_ch;
      if (caps_q && (tab_ch inside {[7'h41:7'h5A], [7'h61:7'h7A]})) begin
        char_d = tab_ch ^ CASE_BIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      prefix_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        shift_q  <= shift_d;
        caps_q   <= caps_d;
        prefix_q <= prefix_d;
      end
      if (out_free) begin
        out_valid_q <= advance && has_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= scan_byte_i;
    end
    if (advance && has_res && out_free) begin
      kind_q <= kind_d;
      char_q <= char_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_kind_o  = kind_q;
  assign char_code_o = char_q;

endmodule

// File: rtl/ps2_set1_scancode_to_ascii_checker.sv
// Port-level checker for the scancode decoder and its bind to the top level.
`timescale 1ns / 1ps

module ps2_set1_scancode_to_ascii_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ps2s1_pkg::kind_e key_kind_o,
  input logic [6:0]       char_code_o
);
  import ps2s1_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_kind_o) &&
      $stable(char_code_o))
    else $error("stalled result changed");

  // Arrow requests carry no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (key_kind_o == KIND_UP || key_kind_o == KIND_DOWN) |->
      char_code_o == 7'd0)
    else $error("arrow request with nonzero character");

  // Character requests never carry a zero table entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_kind_o == KIND_CHAR |-> char_code_o != 7'd0)
    else $error("character request with zero character");

  // The input side never blocks while no byte is held inside the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_valid_i && in_ready_o) |-> in_ready_o)
    else $error("input blocked while empty");

endmodule

bind ps2_set1_scancode_to_ascii_top ps2_set1_scancode_to_ascii_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .key_kind_o  (key_kind_o),
  .char_code_o (char_code_o)
);

// File: tb/tb_top.sv
// Self-checking testbench for the scancode set 1 to ASCII decoder top level.
`timescale 1ns / 1ps

module tb_top;
  import ps2s1_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 310;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [7:0] KEY_CODES = 8'd58;

  localparam logic [6:0] PLAIN_KEYS [58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h23, 7'h00, 7'h23, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  localparam logic [6:0] SHIFTED_KEYS [58] = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h00, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h40, 7'h7E, 7'h00, 7'h7E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  typedef struct packed {
    kind_e      kind;
    logic [6:0] ch;
  } key_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] scan_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  kind_e      key_kind;
  logic [6:0] char_code;

  logic shift_down = 1'b0;
  logic caps_active = 1'b0;
  logic ext_pending = 1'b0;

  key_t        pending_keys [$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned keys_checked = 0;
  int unsigned arrows_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  ps2_set1_scancode_to_ascii_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .scan_byte_i (scan_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_kind_o  (key_kind),
    .char_code_o (char_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic decode_scancode(input logic [7:0] b, output key_t key);
    logic [6:0] ch;
    logic       hit;
    key = '{KIND_CHAR, 7'd0};
    hit = 1'b0;
    if (b == SC_PREFIX) begin
      ext_pending = 1'b1;
    end else if (b == SC_LSHIFT || b == SC_RSHIFT) begin
      shift_down = 1'b1;
    end else if (b == (SC_LSHIFT | SC_BREAK_BIT) || b == (SC_RSHIFT | SC_BREAK_BIT)) begin
      shift_down = 1'b0;
    end else if (b == SC_CAPS) begin
      caps_active = !caps_active;
    end else if (|(b & SC_BREAK_BIT)) begin
      ext_pending = 1'b0;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      if (b == SC_ARROW_UP) begin
        key.kind = KIND_UP;
        hit = 1'b1;
      end else if (b == SC_ARROW_DOWN) begin
        key.kind = KIND_DOWN;
        hit = 1'b1;
      end
    end else if (b < KEY_CODES) begin
      ch = shift_down ? SHIFTED_KEYS[b[5:0]] : PLAIN_KEYS[b[5:0]];
      if (ch != 7'd0) begin
        if (caps_active && ch >= 7'h61 && ch <= 7'h7A) begin
          ch = ch - CASE_BIT;
        end else if (caps_active && ch >= 7'h41 && ch <= 7'h5A) begin
          ch = ch + CASE_BIT;
        end
        key.ch = ch;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic send_scan(input logic [7:0] b);
    key_t key;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    scan_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (decode_scancode(b, key)) pending_keys.push_back(key);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    key_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_keys.size() == 0) begin
          $display("%0t: unexpected key: kind %0d char %h", $time, key_kind, char_code);
          mismatches++;
        end else begin
          want = pending_keys.pop_front();
          keys_checked++;
          if (want.kind != KIND_CHAR) arrows_checked++;
          if (key_kind !== want.kind || char_code !== want.ch) begin
            $display("%0t: key mismatch: expected kind %0d char %h, got kind %0d char %h",
                     $time, want.kind, want.ch, key_kind, char_code);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d keys outstanding.",
               cycles, pending_keys.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_byte_extremes();
    logic [7:0] seq [6];
    seq = '{8'h00, 8'hFF, 8'h02, 8'h39, 8'h3B, 8'h7F};
    foreach (seq[i]) send_scan(seq[i]);
  endtask

  task automatic test_shift_and_caps();
    logic [7:0] seq [10];
    seq = '{SC_LSHIFT, 8'h1E, 8'h04, SC_RSHIFT | SC_BREAK_BIT, SC_CAPS, 8'h1E,
            SC_RSHIFT, 8'h1E, SC_LSHIFT | SC_BREAK_BIT, SC_CAPS};
    foreach (seq[i]) send_scan(seq[i]);
  endtask

  task automatic test_extended_arrows();
    logic [7:0] seq [11];
    seq = '{SC_PREFIX, SC_ARROW_UP, SC_PREFIX, SC_ARROW_DOWN, SC_PREFIX, 8'h9E,
            SC_ARROW_UP, SC_PREFIX, SC_LSHIFT, SC_ARROW_DOWN, SC_LSHIFT | SC_BREAK_BIT};
    foreach (seq[i]) send_scan(seq[i]);
  endtask

  task automatic send_random_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_scan(8'($urandom_range(KEY_CODES - 1)));
    end else if (pick < 50) begin
      case ($urandom_range(3))
        0: send_scan(SC_LSHIFT);
        1: send_scan(SC_RSHIFT);
        2: send_scan(SC_LSHIFT | SC_BREAK_BIT);
        default: send_scan(SC_RSHIFT | SC_BREAK_BIT);
      endcase
    end else if (pick < 55) begin
      send_scan(SC_CAPS);
    end else if (pick < 70) begin
      send_scan(SC_PREFIX);
      if ($urandom_range(4) == 0) send_scan(SC_LSHIFT);
      case ($urandom_range(3))
        0: send_scan(SC_ARROW_UP);
        1: send_scan(SC_ARROW_DOWN);
        2: send_scan(8'($urandom_range(127)));
        default: send_scan(8'($urandom_range(127)) | SC_BREAK_BIT);
      endcase
    end else if (pick < 80) begin
      send_scan(8'($urandom_range(KEY_CODES - 1)) | SC_BREAK_BIT);
    end else begin
      send_scan(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random_typing(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned start;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_ITEMS) send_random_key();
    hold_until_drained();
  endtask

  task automatic test_random_streaming();
    run_random_typing(0, 0);
  endtask

  task automatic test_random_sender_gaps();
    run_random_typing(76, 0);
  endtask

  task automatic test_random_receiver_stalls();
    run_random_typing(0, 76);
  endtask

  task automatic test_random_both_idle();
    run_random_typing(26, 26);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_byte_extremes();
    test_shift_and_caps();
    test_extended_arrows();
    hold_until_drained();
    test_random_streaming();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d scancodes through directed cases and four timing phases.", bytes_sent);
    $display("Checked %0d decoded keys, %0d of them arrows.", keys_checked, arrows_checked);
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d keys never arrived.", mismatches, pending_keys.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ps2s1_pkg.sv
rtl/ps2_set1_scancode_to_ascii_top.sv
rtl/ps2_set1_scancode_to_ascii_checker.sv
tb/tb_top.sv
